### sv/nearest_neighbor_tour_assert.svh
// Assertion macros used by the checker file nnt_checker.sv.
`ifndef NEAREST_NEIGHBOR_TOUR_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NNT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nnt assertion failed");

// Next-cycle implication, disabled while reset is low.
`define NNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnt assertion failed");

`endif

### sv/nnt_pkg.sv
`default_nettype none

package nnt_pkg;

    localparam int CITY_W         = 5;
    localparam int DIST_W         = 32;
    localparam int CFG_W          = 6;
    localparam int MAX_CITIES_DEF = 32;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_CITY_COUNT  = 3'd0;
    localparam logic [CFG_W-1:0]      CITY_COUNT_RESET = 6'd32;
    localparam logic [DIST_W-1:0]     NO_EDGE          = 32'hFFFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BUILD = 1'b1;

endpackage

`default_nettype wire

### sv/nearest_neighbor_tour.sv
// Channel  | Handshake         | Payload
// s_       | s_tvalid/s_tready | s_tuser opcode; s_tdata from, to, distance, start
// m_       | m_tvalid/m_tready | m_tdata city; m_tlast closes the tour
// apb      | psel/penable      | city_count at byte address 0
//
// A build with n cities runs a matrix scan, bounded by the single read port of
// the distance memory, then emits n+1 results: each of n cities passes S_EMIT_RD
// and S_EMIT_LD, and the closing city 0 passes S_CLOSE.
// One item is in work at a time; s_tready is high only while the block is idle.
// The output register holds a result until m_tready takes it; the last result
// may still wait there while the next item is accepted.
// rst_n clears control state and sets city_count to 32; the memories keep junk.
`default_nettype none

module nearest_neighbor_tour #(
    parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [4:0] from_city, [9:5] to_city, [41:10] distance, [46:42] start_city, [47] zero
    input  wire  [nnt_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] opcode
    input  wire                              s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [4:0] city, [7:5] zero
    output logic [nnt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [nnt_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [nnt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nnt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int CW    = $clog2(MAX_CITIES);
    localparam int NW    = $clog2(MAX_CITIES + 1);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_LD = 3'd4;
    localparam logic [2:0] S_CLOSE   = 3'd5;

    // Input fields
    logic [nnt_pkg::CITY_W-1:0] from_f;
    logic [nnt_pkg::CITY_W-1:0] to_f;
    logic [nnt_pkg::DIST_W-1:0] dist_f;
    logic [nnt_pkg::CITY_W-1:0] start_f;

    assign from_f  = s_tdata[4:0];
    assign to_f    = s_tdata[9:5];
    assign dist_f  = s_tdata[41:10];
    assign start_f = s_tdata[46:42];

    logic [2:0]                  state_reg;
    logic [nnt_pkg::CFG_W-1:0]   city_count_reg;
    logic [NW-1:0]               n_reg;
    logic [CW-1:0]               cur_reg;
    logic [CW-1:0]               j_reg;
    logic [CW-1:0]               jd_reg;
    logic                        rvalid_reg;
    logic [nnt_pkg::DIST_W-1:0]  best_reg;
    logic [CW-1:0]               best_city_reg;
    logic [CW-1:0]               step_reg;
    logic [NW-1:0]               k_reg;
    logic [MAX_CITIES-1:0]       visited_reg;
    logic [CW-1:0]               emit_addr_reg;
    logic [CW-1:0]               emit_cnt_reg;
    logic                        out_valid_reg;
    logic [nnt_pkg::CITY_W-1:0]  out_city_reg;
    logic                        out_last_reg;

    logic accept;
    logic cfg_wr;
    logic out_free;

    assign accept   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(nnt_pkg::M_TDATA_W - nnt_pkg::CITY_W){1'b0}}, out_city_reg};
    assign m_tlast  = out_last_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == nnt_pkg::ADDR_CITY_COUNT)
                      ? {{(nnt_pkg::APB_DATA_W - nnt_pkg::CFG_W){1'b0}}, city_count_reg}
                      : '0;

    // Clamp the city count and the start city
    logic [NW-1:0] n_comb;
    logic [CW-1:0] start_comb;
    logic [NW-1:0] n_m1;

    always_comb
    begin
        priority if (32'(city_count_reg) < 32'd2)
            n_comb = NW'(2);
        else if (32'(city_count_reg) > 32'(MAX_CITIES))
            n_comb = NW'(MAX_CITIES);
        else
            n_comb = NW'(city_count_reg);
        if (32'(start_f) > 32'(n_comb) - 32'd1)
            start_comb = CW'(32'(n_comb) - 32'd1);
        else
            start_comb = CW'(start_f);
    end

    assign n_m1 = n_reg - NW'(1);

    // Distance memory
    logic [nnt_pkg::DIST_W-1:0] dist_mem [DEPTH];
    logic [nnt_pkg::DIST_W-1:0] dist_q;
    logic                       dist_we;
    logic [AW-1:0]              dist_waddr;
    logic [AW-1:0]              dist_raddr;

    assign dist_we = accept && (s_tuser == nnt_pkg::OP_WRITE)
                     && (32'(from_f) < 32'(MAX_CITIES)) && (32'(to_f) < 32'(MAX_CITIES));
    assign dist_waddr = {CW'(from_f), CW'(to_f)};
    assign dist_raddr = {cur_reg, j_reg};

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_waddr] <= dist_f;
        dist_q <= dist_mem[dist_raddr];
    end

    // Scan compare on the word that arrives this cycle
    logic                       take;
    logic [CW-1:0]              best_city_new;
    logic [nnt_pkg::DIST_W-1:0] best_new;
    logic [NW-1:0]              k_new;

    assign take          = rvalid_reg && !visited_reg[jd_reg] && (dist_q < best_reg);
    assign best_city_new = take ? jd_reg : best_city_reg;
    assign best_new      = take ? dist_q : best_reg;
    assign k_new         = ((k_reg == n_reg) && (best_city_new == '0)) ? NW'(step_reg) : k_reg;

    // Tour memory
    logic [CW-1:0] tour_mem [MAX_CITIES];
    logic [CW-1:0] tour_q;
    logic          tour_we;
    logic [CW-1:0] tour_waddr;
    logic [CW-1:0] tour_wdata;

    always_comb
    begin
        tour_we    = 1'b0;
        tour_waddr = step_reg;
        tour_wdata = best_city_new;
        if (accept && (s_tuser == nnt_pkg::OP_BUILD))
        begin
            tour_we    = 1'b1;
            tour_waddr = '0;
            tour_wdata = start_comb;
        end
        else if (state_reg == S_DRAIN)
        begin
            tour_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tour_we)
            tour_mem[tour_waddr] <= tour_wdata;
        tour_q <= tour_mem[emit_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            city_count_reg <= nnt_pkg::CITY_COUNT_RESET;
            n_reg          <= '0;
            cur_reg        <= '0;
            j_reg          <= '0;
            jd_reg         <= '0;
            rvalid_reg     <= 1'b0;
            best_reg       <= nnt_pkg::NO_EDGE;
            best_city_reg  <= '0;
            step_reg       <= '0;
            k_reg          <= '0;
            visited_reg    <= '0;
            emit_addr_reg  <= '0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_city_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr == nnt_pkg::ADDR_CITY_COUNT))
                city_count_reg <= pwdata[nnt_pkg::CFG_W-1:0];

            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (s_tuser == nnt_pkg::OP_BUILD))
                    begin
                        n_reg         <= n_comb;
                        cur_reg       <= start_comb;
                        visited_reg   <= {{(MAX_CITIES-1){1'b0}}, 1'b1} << start_comb;
                        step_reg      <= CW'(1);
                        k_reg         <= (start_comb == '0) ? '0 : n_comb;
                        j_reg         <= '0;
                        rvalid_reg    <= 1'b0;
                        best_reg      <= nnt_pkg::NO_EDGE;
                        best_city_reg <= '0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    best_reg      <= best_new;
                    best_city_reg <= best_city_new;
                    rvalid_reg    <= 1'b1;
                    jd_reg        <= j_reg;
                    j_reg         <= j_reg + CW'(1);
                    if (NW'(j_reg) == n_m1)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    // commit the pick of this step
                    visited_reg   <= visited_reg | ({{(MAX_CITIES-1){1'b0}}, 1'b1} << best_city_new);
                    cur_reg       <= best_city_new;
                    k_reg         <= k_new;
                    step_reg      <= step_reg + CW'(1);
                    rvalid_reg    <= 1'b0;
                    j_reg         <= '0;
                    best_reg      <= nnt_pkg::NO_EDGE;
                    best_city_reg <= '0;
                    if (NW'(step_reg) == n_m1)
                    begin
                        emit_addr_reg <= (k_new == n_reg) ? '0 : CW'(k_new);
                        emit_cnt_reg  <= '0;
                        state_reg     <= S_EMIT_RD;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_city_reg  <= nnt_pkg::CITY_W'(tour_q);
                        out_last_reg  <= 1'b0;
                        emit_cnt_reg  <= emit_cnt_reg + CW'(1);
                        // wrap the read pointer at the city count
                        if (NW'(emit_addr_reg) == n_m1)
                            emit_addr_reg <= '0;
                        else
                            emit_addr_reg <= emit_addr_reg + CW'(1);
                        if (NW'(emit_cnt_reg) == n_m1)
                            state_reg <= S_CLOSE;
                        else
                            state_reg <= S_EMIT_RD;
                    end
                end
                S_CLOSE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_city_reg  <= '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/nnt_checker.sv
`default_nettype none

`include "nearest_neighbor_tour_assert.svh"

module nnt_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire [nnt_pkg::S_TDATA_W-1:0]     s_tdata,
    input wire                              s_tuser,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [nnt_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire                              m_tlast
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // hold a stalled result
    `NNT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // the closing item of a tour is city 0
    `NNT_ASSERT_IMPLY(a_close_zero, clk, rst_n, m_tvalid && m_tlast,
        m_tdata[nnt_pkg::CITY_W-1:0] == '0)

    // a build item keeps the input side busy
    `NNT_ASSERT_NEXT(a_build_busy, clk, rst_n, s_acc && (s_tuser == nnt_pkg::OP_BUILD),
        !s_tready)

    // a write item yields no result
    `NNT_ASSERT_NEXT(a_write_silent, clk, rst_n,
        s_acc && (s_tuser == nnt_pkg::OP_WRITE) && !m_tvalid, !m_tvalid)

    logic unused_data;

    assign unused_data = ^s_tdata;

endmodule

bind nearest_neighbor_tour nnt_checker u_nnt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
